FILE: rtl/chtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtg_pkg
// Shared constants and types of the CIP header timestamp generator.
// ----------------------------------------------------------------------------
package chtg_pkg;

  localparam int unsigned TICK_WRAP         = 3072;
  localparam int unsigned CYCLES_PER_SECOND = 8000;
  localparam int unsigned TICKS_PER_SECOND  = 24576000;
  localparam int unsigned SYT_DELAY_TICKS   = 9000;
  localparam int unsigned RATE_MIN          = 32000;
  localparam int unsigned RATE_MAX          = 192000;
  localparam int unsigned INTERVAL_MAX      = 32;
  localparam int unsigned READY_MAX         = 127;

  localparam logic [15:0] NO_TIMESTAMP = 16'hFFFF;
  localparam logic [7:0]  NODATA_FDF   = 8'hFF;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_TX_MODE   = 3'd0;
  localparam logic [2:0] REG_RATE      = 3'd1;
  localparam logic [2:0] REG_INTERVAL  = 3'd2;
  localparam logic [2:0] REG_DBS       = 3'd3;
  localparam logic [2:0] REG_FMT       = 3'd4;
  localparam logic [2:0] REG_FDF       = 3'd5;

  // Transmit modes.
  localparam logic [1:0] MODE_NONBLOCKING   = 2'd0;
  localparam logic [1:0] MODE_BLOCK_EMPTY   = 2'd1;
  localparam logic [1:0] MODE_BLOCK_NODATA  = 2'd2;

  // Reset values of the registers and of the derived fractions.
  localparam int unsigned RST_RATE     = 48000;
  localparam int unsigned RST_INTERVAL = 8;
  localparam logic [1:0]  RST_MODE     = MODE_BLOCK_EMPTY;
  localparam logic [7:0]  RST_DBS      = 8'd2;
  localparam logic [5:0]  RST_FMT      = 6'd16;
  localparam logic [7:0]  RST_FDF      = 8'd2;

  localparam logic [4:0]  RST_PC_WHOLE  = 5'(RST_RATE / CYCLES_PER_SECOND);
  localparam logic [12:0] RST_PC_REM    = 13'(RST_RATE % CYCLES_PER_SECOND);
  localparam longint unsigned RST_NUM   = longint'(TICKS_PER_SECOND) * RST_INTERVAL;
  localparam logic [14:0] RST_STEP_TICKS = 15'(RST_NUM / RST_RATE);
  localparam logic [17:0] RST_STEP_REM   = 18'(RST_NUM % RST_RATE);

  localparam logic [3:0]  RST_CYCLE  = 4'(SYT_DELAY_TICKS / TICK_WRAP);
  localparam logic [11:0] RST_OFFSET = 12'(SYT_DELAY_TICKS % TICK_WRAP);

  // Effective configuration seen by the per-cycle datapath.
  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  interval;     // clamped to 1..32
    logic [17:0] rate;         // clamped to 32000..192000
    logic [7:0]  dbs;
    logic [5:0]  fmt;
    logic [7:0]  fdf;
    logic [4:0]  pc_whole;     // rate / 8000
    logic [12:0] pc_rem;       // rate % 8000
    logic [14:0] step_ticks;   // 24576000 * interval / rate
    logic [17:0] step_rem;     // remainder of that division
  } cfg_t;

endpackage

FILE: rtl/chtg_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtg_cfg
// Configuration registers, the shift-subtract divider that derives the
// timestamp step after each write other than to tx_mode, and a reciprocal
// multiply for the samples per cycle.
// ----------------------------------------------------------------------------
module chtg_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [17:0]      cfg_wdata,
  output chtg_pkg::cfg_t   cfg,
  output logic             busy,
  output logic             reinit
);
  import chtg_pkg::*;

  localparam int unsigned NSTEPS   = 15;
  // rate / 8000 = (rate >> 6) / 125, and x / 125 = (x * 8389) >> 20 is exact
  // for every x below 21000, well above the largest clamped rate >> 6.
  localparam int unsigned PC_RECIP = 8389;

  logic [1:0]  mode_r, mode_nxt;
  logic [17:0] rate_r, rate_nxt;
  logic [5:0]  iv_r, iv_nxt;
  logic [7:0]  dbs_r, dbs_nxt;
  logic [5:0]  fmt_r, fmt_nxt;
  logic [7:0]  fdf_r, fdf_nxt;

  logic        busy_r, busy_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [17:0] part_r, part_nxt;
  logic [14:0] bits_r, bits_nxt;
  logic [12:0] pc_part_r, pc_part_nxt;
  logic [4:0]  pc_bits_r, pc_bits_nxt;
  logic        reinit_r, reinit_nxt;

  logic        start;
  logic [17:0] raw_rate;
  logic [5:0]  raw_iv;
  logic [29:0] num;
  logic [18:0] trial;
  logic        ge;
  logic [24:0] pc_prod;
  logic [4:0]  pc_q;

  assign start    = cfg_we && (cfg_index >= REG_RATE) && (cfg_index <= REG_FDF);
  assign raw_rate = cfg_wdata;
  assign raw_iv   = cfg_wdata[5:0];

  always_comb begin
    mode_nxt = mode_r;
    rate_nxt = rate_r;
    iv_nxt   = iv_r;
    dbs_nxt  = dbs_r;
    fmt_nxt  = fmt_r;
    fdf_nxt  = fdf_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_TX_MODE: mode_nxt = cfg_wdata[1:0];
        REG_RATE: begin
          if (raw_rate < 18'(RATE_MIN)) begin
            rate_nxt = 18'(RATE_MIN);
          end else if (raw_rate > 18'(RATE_MAX)) begin
            rate_nxt = 18'(RATE_MAX);
          end else begin
            rate_nxt = raw_rate;
          end
        end
        REG_INTERVAL: begin
          if (raw_iv == 6'd0) begin
            iv_nxt = 6'd1;
          end else if (raw_iv > 6'(INTERVAL_MAX)) begin
            iv_nxt = 6'(INTERVAL_MAX);
          end else begin
            iv_nxt = raw_iv;
          end
        end
        REG_DBS: dbs_nxt = cfg_wdata[7:0];
        REG_FMT: fmt_nxt = cfg_wdata[5:0];
        REG_FDF: fdf_nxt = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // The quotient of 24576000 * interval / rate never exceeds 15 bits, so the
  // upper 15 numerator bits already sit below the divisor and seed the
  // partial remainder.
  assign num      = 30'(TICKS_PER_SECOND) * 30'(iv_nxt);
  assign trial    = {part_r, bits_r[14]};
  assign ge       = trial >= {1'b0, rate_r};
  assign pc_prod  = 25'(rate_r[17:6]) * 25'(PC_RECIP);
  assign pc_q     = pc_prod[24:20];

  always_comb begin
    busy_nxt    = busy_r;
    step_nxt    = step_r;
    part_nxt    = part_r;
    bits_nxt    = bits_r;
    pc_part_nxt = pc_part_r;
    pc_bits_nxt = pc_bits_r;
    reinit_nxt  = start;
    if (start) begin
      busy_nxt    = 1'b1;
      step_nxt    = 4'd0;
      part_nxt    = {3'b000, num[29:15]};
      bits_nxt    = num[14:0];
    end else if (busy_r) begin
      part_nxt = ge ? 18'(trial - {1'b0, rate_r}) : trial[17:0];
      bits_nxt = {bits_r[13:0], ge};
      // The new rate is registered by now; take the samples per cycle once.
      if (step_r == 4'd0) begin
        pc_bits_nxt = pc_q;
        pc_part_nxt = 13'(rate_r - 18'(pc_q) * 18'(CYCLES_PER_SECOND));
      end
      step_nxt = step_r + 4'd1;
      if (step_r == 4'(NSTEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= RST_MODE;
      rate_r    <= 18'(RST_RATE);
      iv_r      <= 6'(RST_INTERVAL);
      dbs_r     <= RST_DBS;
      fmt_r     <= RST_FMT;
      fdf_r     <= RST_FDF;
      busy_r    <= 1'b0;
      step_r    <= 4'd0;
      part_r    <= RST_STEP_REM;
      bits_r    <= RST_STEP_TICKS;
      pc_part_r <= RST_PC_REM;
      pc_bits_r <= RST_PC_WHOLE;
      reinit_r  <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      rate_r    <= rate_nxt;
      iv_r      <= iv_nxt;
      dbs_r     <= dbs_nxt;
      fmt_r     <= fmt_nxt;
      fdf_r     <= fdf_nxt;
      busy_r    <= busy_nxt;
      step_r    <= step_nxt;
      part_r    <= part_nxt;
      bits_r    <= bits_nxt;
      pc_part_r <= pc_part_nxt;
      pc_bits_r <= pc_bits_nxt;
      reinit_r  <= reinit_nxt;
    end
  end

  assign cfg.mode       = mode_r;
  assign cfg.interval   = iv_r;
  assign cfg.rate       = rate_r;
  assign cfg.dbs        = dbs_r;
  assign cfg.fmt        = fmt_r;
  assign cfg.fdf        = fdf_r;
  assign cfg.pc_whole   = pc_bits_r;
  assign cfg.pc_rem     = pc_part_r;
  assign cfg.step_ticks = bits_r;
  assign cfg.step_rem   = part_r;
  assign busy           = busy_r;
  assign reinit         = reinit_r;

endmodule

FILE: rtl/chtg_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtg_step
// Per-cycle header datapath: input register, sample and timestamp state,
// and the result register.
// ----------------------------------------------------------------------------
module chtg_step (
  input  logic            clk,
  input  logic            rst_n,
  input  chtg_pkg::cfg_t  cfg,
  input  logic            busy,
  input  logic            reinit,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [5:0]      in_node_id,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [63:0]     out_tdata
);
  import chtg_pkg::*;

  logic        in_vld_r;
  logic [5:0]  node_r;
  logic        mv;

  logic [6:0]  ready_whole_r, ready_whole_nxt;
  logic [12:0] ready_rem_r, ready_rem_nxt;
  logic [7:0]  dbc_r, dbc_nxt;
  logic [3:0]  cyc_r, cyc_nxt;
  logic [11:0] ofs_r, ofs_nxt;
  logic [17:0] ofs_rem_r, ofs_rem_nxt;

  logic        out_vld_r;
  logic [5:0]  o_events_r, o_sid_r, o_fmt_r;
  logic [7:0]  o_dbs_r, o_dbc_r, o_fdf_r;
  logic [15:0] o_syt_r;

  logic        blocking, nodata;
  logic [13:0] rem_sum;
  logic        rem_carry;
  logic [7:0]  next_whole, nevents, dbc_step, left, idx;
  logic        ts_hit;
  logic [18:0] osum;
  logic        ocarry;
  logic [14:0] ticks;
  logic [8:0]  q_prod;
  logic [3:0]  q;
  logic [14:0] wrap_sub;
  logic [15:0] syt;
  logic [7:0]  fdf;

  assign mv        = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !busy && (!in_vld_r || mv);

  assign blocking = (cfg.mode == MODE_BLOCK_EMPTY) || (cfg.mode == MODE_BLOCK_NODATA);
  assign nodata   = (cfg.mode == MODE_BLOCK_NODATA);

  always_comb begin
    rem_sum    = 14'(ready_rem_r) + 14'(cfg.pc_rem);
    rem_carry  = rem_sum >= 14'(CYCLES_PER_SECOND);
    ready_rem_nxt = rem_carry ? 13'(rem_sum - 14'(CYCLES_PER_SECOND)) : rem_sum[12:0];
    next_whole = 8'(ready_whole_r) + 8'(cfg.pc_whole) + 8'(rem_carry);

    if (blocking) begin
      nevents = (next_whole >= 8'(cfg.interval)) ? 8'(cfg.interval) : 8'd0;
    end else begin
      nevents = next_whole;
    end
    dbc_step = nodata ? 8'(cfg.interval) : nevents;
    left     = next_whole - nevents;
    ready_whole_nxt = (left > 8'(READY_MAX)) ? 7'(READY_MAX) : left[6:0];
    dbc_nxt  = dbc_r + dbc_step;

    // A timestamp goes with the packet that carries the event whose index is
    // a multiple of the interval, when the interval is a power of two.
    idx    = (8'(cfg.interval) - dbc_r) & 8'(cfg.interval - 6'd1);
    ts_hit = idx < nevents;

    osum   = 19'(ofs_rem_r) + 19'(cfg.step_rem);
    ocarry = osum >= {1'b0, cfg.rate};
    ticks  = 15'(ofs_r) + cfg.step_ticks + 15'(ocarry);
    // ticks / 3072 = (ticks / 1024) / 3, and x / 3 = (x * 11) >> 5 for x < 28.
    q_prod   = 9'(ticks[14:10]) * 9'd11;
    q        = q_prod[8:5];
    wrap_sub = {q, 11'b0} + {1'b0, q, 10'b0};

    syt         = NO_TIMESTAMP;
    cyc_nxt     = cyc_r;
    ofs_nxt     = ofs_r;
    ofs_rem_nxt = ofs_rem_r;
    if (ts_hit) begin
      syt         = {cyc_r, ofs_r};
      ofs_rem_nxt = ocarry ? 18'(osum - {1'b0, cfg.rate}) : osum[17:0];
      cyc_nxt     = cyc_r + q;
      ofs_nxt     = 12'(ticks - wrap_sub);
    end

    fdf = (nevents == 8'd0 && nodata) ? NODATA_FDF : cfg.fdf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      ready_whole_r <= '0;
      ready_rem_r   <= '0;
      dbc_r         <= '0;
      cyc_r         <= RST_CYCLE;
      ofs_r         <= RST_OFFSET;
      ofs_rem_r     <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_vld_r <= 1'b1;
      end else if (mv) begin
        in_vld_r <= 1'b0;
      end

      if (mv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end

      if (reinit) begin
        ready_whole_r <= '0;
        ready_rem_r   <= '0;
        dbc_r         <= '0;
        cyc_r         <= RST_CYCLE;
        ofs_r         <= RST_OFFSET;
        ofs_rem_r     <= '0;
      end else if (mv) begin
        ready_whole_r <= ready_whole_nxt;
        ready_rem_r   <= ready_rem_nxt;
        dbc_r         <= dbc_nxt;
        cyc_r         <= cyc_nxt;
        ofs_r         <= ofs_nxt;
        ofs_rem_r     <= ofs_rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      node_r <= in_node_id;
    end
    if (mv) begin
      o_events_r <= nevents[5:0];
      o_sid_r    <= node_r;
      o_dbs_r    <= cfg.dbs;
      o_dbc_r    <= dbc_r;
      o_fmt_r    <= cfg.fmt;
      o_fdf_r    <= fdf;
      o_syt_r    <= syt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, o_syt_r, o_fdf_r, o_fmt_r, o_dbc_r, o_dbs_r, o_sid_r,
                       o_events_r};

endmodule

FILE: rtl/cip_header_timestamp_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cip_header_timestamp_generator_unit
// Builds one CIP header (SID, DBS, DBC, FMT, FDF, SYT and the event count)
// for each isochronous cycle transfer on the input stream.
// ----------------------------------------------------------------------------
// One header per input transfer, one transfer per clock when both sides flow
// and the divider is idle. A transfer passes an input register and a result
// register, so its header is on out_tdata once it reaches the result register
// and leaves when out_tready is high; the input register can still take one
// transfer while a finished header waits. A write of any register except
// tx_mode restarts the sample and timestamp state and runs a shift-subtract
// divider, one quotient bit per clock, that derives the timestamp step from
// the rate and interval: in_tready stays low while it runs. A tx_mode write
// takes effect without a restart or a divider run.
module cip_header_timestamp_generator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [5:0] local_node_id, [7:6] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] event_count, [11:6] source_id, [19:12] block_size,
  // [27:20] block_count, [33:28] format_code, [41:34] format_dependent,
  // [57:42] sync_timestamp, [63:58] zero
  output logic [63:0] out_tdata
);
  import chtg_pkg::*;

  cfg_t cfg;
  logic busy;
  logic reinit;

  chtg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .busy      (busy),
    .reinit    (reinit)
  );

  chtg_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .busy       (busy),
    .reinit     (reinit),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_node_id (in_tdata[5:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
